// File: sv/imu_accel_bias_calibrator_assert.svh
// Assertion macros shared by the calibrator RTL.
`ifndef IMU_ACCEL_BIAS_CALIBRATOR_ASSERT_SVH
`define IMU_ACCEL_BIAS_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IABC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iabc assertion failed");

// Next-cycle implication, disabled during reset.
`define IABC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iabc assertion failed");

`endif

// File: sv/iabc_pkg.sv
// Package: widths, constants and fixed-point helpers of the calibrator.
package iabc_pkg;
    localparam int ACCEL_BITS = 16;
    localparam int QF         = 14;
    localparam int COUNT_BITS = 16;
    localparam int QB         = QF + 2;
    localparam int WB         = ACCEL_BITS + 1;
    localparam int PRB        = 2 * QB - QF + 2;
    localparam int MB         = PRB + 3;
    localparam int SUMB       = WB + COUNT_BITS + 1;
    localparam int DB         = SUMB + 2;
    localparam int PB         = MB + DB;
    localparam int ACCB       = PB + 2;
    localparam int HALF_B     = DB / 2;

    localparam logic [1:0] CFG_AVG_LEN   = 2'd0;
    localparam logic [1:0] CFG_PRESET_X  = 2'd1;
    localparam logic [1:0] CFG_PRESET_Y  = 2'd2;
    localparam logic [1:0] CFG_PRESET_Z  = 2'd3;

    localparam logic [1:0] PH_QUAT  = 2'd0;
    localparam logic [1:0] PH_WORLD = 2'd1;
    localparam logic [1:0] PH_BACK  = 2'd2;

    localparam logic [COUNT_BITS-1:0] AVG_LEN_RST = COUNT_BITS'(100);

    // Round half away from zero, dropping QF fraction bits.
    function automatic logic signed [ACCB-1:0] rnd_q(input logic signed [ACCB-1:0] v);
        logic signed [ACCB-1:0] h;
        h = v[ACCB-1] ? ACCB'((1 << (QF - 1)) - 1) : ACCB'(1 << (QF - 1));
        return (v + h) >>> QF;
    endfunction

    function automatic logic signed [WB-1:0] sat_w(input logic signed [ACCB-1:0] v);
        logic signed [ACCB-1:0] hi;
        logic signed [ACCB-1:0] lo;
        hi = ACCB'((1 << (WB - 1)) - 1);
        lo = -hi - ACCB'(1);
        if (v > hi) return WB'(hi);
        if (v < lo) return WB'(lo);
        return v[WB-1:0];
    endfunction

    function automatic logic signed [ACCEL_BITS-1:0] sat_a(input logic signed [ACCB-1:0] v);
        logic signed [ACCB-1:0] hi;
        logic signed [ACCB-1:0] lo;
        hi = ACCB'((1 << (ACCEL_BITS - 1)) - 1);
        lo = -hi - ACCB'(1);
        if (v > hi) return ACCEL_BITS'(hi);
        if (v < lo) return ACCEL_BITS'(lo);
        return v[ACCEL_BITS-1:0];
    endfunction
endpackage

// File: sv/iabc_mul.sv
// Shared two-stage signed multiplier (split wide operand, registered partials).
module iabc_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [iabc_pkg::MB-1:0]    i_a,
    input  logic signed [iabc_pkg::DB-1:0]    i_b,
    output logic                              o_valid,
    output logic signed [iabc_pkg::PB-1:0]    o_prod
);
    import iabc_pkg::*;

    logic                           r_v1;
    logic signed [MB+HALF_B:0]      r_plo;
    logic signed [MB+DB-HALF_B-1:0] r_phi;
    logic                           r_v2;
    logic signed [PB-1:0]           r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        if (i_start) begin
            r_plo <= i_a * $signed({1'b0, i_b[HALF_B-1:0]});
            r_phi <= i_a * $signed(i_b[DB-1:HALF_B]);
        end
        if (r_v1) begin
            r_prod <= (PB'(r_phi) <<< HALF_B) + PB'(r_plo);
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
endmodule

// File: sv/iabc_div.sv
// Iterative restoring divider, signed dividend, truncation toward zero.
module iabc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [iabc_pkg::SUMB-1:0]   i_num,
    input  logic [iabc_pkg::COUNT_BITS-1:0]    i_den,
    output logic                               o_done,
    output logic signed [iabc_pkg::SUMB-1:0]   o_quo
);
    import iabc_pkg::*;

    localparam int CW = $clog2(SUMB + 1);

    logic                     r_busy;
    logic [CW-1:0]            r_cnt;
    logic [COUNT_BITS:0]      r_rem;
    logic [SUMB-1:0]          r_quo;
    logic                     r_neg;
    logic                     r_done;
    logic [COUNT_BITS:0]      w_shift;
    logic [COUNT_BITS+1:0]    w_trial;

    assign w_shift = {r_rem[COUNT_BITS-1:0], r_quo[SUMB-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(SUMB - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_neg <= i_num[SUMB-1];
            r_quo <= i_num[SUMB-1] ? SUMB'(-i_num) : SUMB'(i_num);
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            // keep the shifted remainder when the trial subtract goes negative
            if (!w_trial[COUNT_BITS+1]) begin
                r_rem <= w_trial[COUNT_BITS:0];
                r_quo <= {r_quo[SUMB-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[SUMB-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

// File: sv/imu_accel_bias_calibrator.sv
// Top level: accelerometer bias calibrator with shared multiplier and divider.
//
// Each accepted request is a start-calibration event or an IMU sample (Q1.14
// quaternion plus raw 16-bit acceleration). A start event clears the running
// sum and sample count, arms calibration and yields no result. A sample is
// rotated into the world frame (R*a); while calibrating the world vector is
// summed and the raw acceleration is returned, and after the configured number
// of samples the sums are divided into the bias. Otherwise the bias (preset,
// until a calibration has completed) is subtracted and the difference rotated
// back with R transposed, saturated to 16 bits. All products (nine for the
// quaternion, nine for R*a and, on a corrected sample, nine for the back
// rotation) go through one two-stage multiplier, one at a time; a sample that
// completes calibration also runs three 34-step divides on the shared divider,
// and every result waits for a free output register. o_stall is high from the
// acceptance of a sample until its result enters the output register.
// Configuration is written with i_cfg_we/i_cfg_idx.
module imu_accel_bias_calibrator (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [1:0]                                i_cfg_idx,
    input  logic [iabc_pkg::WB-1:0]                   i_cfg_data,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic                                      i_kind,
    input  logic signed [iabc_pkg::QB-1:0]            i_quat_w,
    input  logic signed [iabc_pkg::QB-1:0]            i_quat_x,
    input  logic signed [iabc_pkg::QB-1:0]            i_quat_y,
    input  logic signed [iabc_pkg::QB-1:0]            i_quat_z,
    input  logic signed [iabc_pkg::ACCEL_BITS-1:0]    i_accel_x,
    input  logic signed [iabc_pkg::ACCEL_BITS-1:0]    i_accel_y,
    input  logic signed [iabc_pkg::ACCEL_BITS-1:0]    i_accel_z,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [iabc_pkg::ACCEL_BITS-1:0]    o_out_x,
    output logic signed [iabc_pkg::ACCEL_BITS-1:0]    o_out_y,
    output logic signed [iabc_pkg::ACCEL_BITS-1:0]    o_out_z,
    output logic                                      o_corrected,
    output logic                                      o_calib_done,
    output logic signed [iabc_pkg::WB-1:0]            o_bias_out_x,
    output logic signed [iabc_pkg::WB-1:0]            o_bias_out_y,
    output logic signed [iabc_pkg::WB-1:0]            o_bias_out_z
);
    import iabc_pkg::*;
    `include "imu_accel_bias_calibrator_assert.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ISSUE  = 4'd1;
    localparam logic [3:0] S_WAIT   = 4'd2;
    localparam logic [3:0] S_MAT    = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_DIVGO  = 4'd5;
    localparam logic [3:0] S_DIVW   = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;

    // configuration
    logic [COUNT_BITS-1:0]        r_avg_len;
    logic signed [WB-1:0]         r_preset [0:2];

    // calibration state
    logic signed [SUMB-1:0]       r_store [0:2];
    logic [COUNT_BITS-1:0]        r_taken;
    logic                         r_calib;
    logic                         r_meas_ok;

    // sequencer
    logic [3:0]                   r_state;
    logic [1:0]                   r_phase;
    logic [1:0]                   r_i;
    logic [1:0]                   r_j;
    logic [1:0]                   r_dc;
    logic signed [ACCB-1:0]       r_acc;

    // working registers of one sample
    logic signed [QB-1:0]         r_qw, r_qx, r_qy, r_qz;
    logic signed [ACCEL_BITS-1:0] r_a [0:2];
    logic signed [PRB-1:0]        r_pr [0:2][0:2];
    logic signed [MB-1:0]         r_m [0:2][0:2];
    logic signed [WB-1:0]         r_wv [0:2];
    logic signed [DB-1:0]         r_d [0:2];
    logic signed [ACCEL_BITS-1:0] r_ro [0:2];
    logic signed [WB-1:0]         r_rb [0:2];
    logic                         r_rcorr;
    logic                         r_rdone;

    // output register
    logic                         r_ovalid;
    logic signed [ACCEL_BITS-1:0] r_o [0:2];
    logic signed [WB-1:0]         r_ob [0:2];
    logic                         r_ocorr;
    logic                         r_odone;

    // shared units
    logic                         w_mul_start;
    logic signed [MB-1:0]         w_mul_a;
    logic signed [DB-1:0]         w_mul_b;
    logic                         w_mul_valid;
    logic signed [PB-1:0]         w_mul_prod;
    logic                         w_div_start;
    logic                         w_div_done;
    logic signed [SUMB-1:0]       w_div_quo;

    logic                         w_in_acc;
    logic                         w_out_free;
    logic [COUNT_BITS-1:0]        w_target;
    logic [COUNT_BITS-1:0]        w_taken_n;
    logic [1:0]                   w_ri, w_ci;
    logic signed [QB-1:0]         w_qa, w_qb;
    logic signed [ACCB-1:0]       w_sum;
    logic signed [ACCB-1:0]       w_rnd;
    logic signed [MB-1:0]         w_one;

    assign w_in_acc   = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_target   = (r_avg_len == '0) ? COUNT_BITS'(1) : r_avg_len;
    assign w_taken_n  = (r_taken == '1) ? r_taken : r_taken + COUNT_BITS'(1);
    assign w_one      = MB'(1 << QF);

    // quaternion products in {i,j} order: xx yy zz / xy xz yz / wx wy wz
    always_comb begin
        w_qa = r_qx;
        w_qb = r_qx;
        case ({r_i, r_j})
            4'h0: begin w_qa = r_qx; w_qb = r_qx; end
            4'h1: begin w_qa = r_qy; w_qb = r_qy; end
            4'h2: begin w_qa = r_qz; w_qb = r_qz; end
            4'h4: begin w_qa = r_qx; w_qb = r_qy; end
            4'h5: begin w_qa = r_qx; w_qb = r_qz; end
            4'h6: begin w_qa = r_qy; w_qb = r_qz; end
            4'h8: begin w_qa = r_qw; w_qb = r_qx; end
            4'h9: begin w_qa = r_qw; w_qb = r_qy; end
            4'hA: begin w_qa = r_qw; w_qb = r_qz; end
            default: begin w_qa = r_qx; w_qb = r_qx; end
        endcase
    end

    // transpose for the back rotation: read one matrix entry per product
    assign w_ri = (r_phase == PH_BACK) ? r_j : r_i;
    assign w_ci = (r_phase == PH_BACK) ? r_i : r_j;

    always_comb begin
        case (r_phase)
            PH_QUAT: begin
                w_mul_a = MB'(w_qa);
                w_mul_b = DB'(w_qb);
            end
            PH_WORLD: begin
                w_mul_a = r_m[w_ri][w_ci];
                w_mul_b = DB'(r_a[r_j]);
            end
            default: begin
                w_mul_a = r_m[w_ri][w_ci];
                w_mul_b = r_d[r_j];
            end
        endcase
    end

    // quaternion products stand alone; matrix rows accumulate over the columns
    assign w_mul_start = (r_state == S_ISSUE);
    assign w_sum = ((r_j == 2'd0 || r_phase == PH_QUAT) ? ACCB'(0) : r_acc)
                   + ACCB'(w_mul_prod);
    assign w_rnd = rnd_q(w_sum);
    assign w_div_start = (r_state == S_DIVGO);

    iabc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_valid (w_mul_valid),
        .o_prod  (w_mul_prod)
    );

    iabc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_store[r_dc]),
        .i_den   (w_target),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_len   <= AVG_LEN_RST;
            r_preset[0] <= '0;
            r_preset[1] <= '0;
            r_preset[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AVG_LEN:  r_avg_len   <= i_cfg_data[COUNT_BITS-1:0];
                CFG_PRESET_X: r_preset[0] <= i_cfg_data;
                CFG_PRESET_Y: r_preset[1] <= i_cfg_data;
                CFG_PRESET_Z: r_preset[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_QUAT;
            r_i       <= '0;
            r_j       <= '0;
            r_dc      <= '0;
            r_taken   <= '0;
            r_calib   <= 1'b0;
            r_meas_ok <= 1'b0;
            r_store[0] <= '0;
            r_store[1] <= '0;
            r_store[2] <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one replaces it now
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_kind) begin
                            // restart: clear the sums and count
                            r_store[0] <= '0;
                            r_store[1] <= '0;
                            r_store[2] <= '0;
                            r_taken    <= '0;
                            r_calib    <= 1'b1;
                        end else begin
                            r_qw    <= i_quat_w;
                            r_qx    <= i_quat_x;
                            r_qy    <= i_quat_y;
                            r_qz    <= i_quat_z;
                            r_a[0]  <= i_accel_x;
                            r_a[1]  <= i_accel_y;
                            r_a[2]  <= i_accel_z;
                            r_phase <= PH_QUAT;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_mul_valid) begin
                        r_acc <= w_sum;
                        if (r_phase == PH_QUAT) begin
                            r_pr[r_i][r_j] <= w_rnd[PRB-1:0];
                        end else if (r_j == 2'd2 && r_phase == PH_WORLD) begin
                            r_wv[r_i] <= sat_w(w_rnd);
                        end else if (r_j == 2'd2) begin
                            r_ro[r_i] <= sat_a(w_rnd);
                        end
                        // advance column, then row, then leave the phase
                        if (r_j != 2'd2) begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_ISSUE;
                        end else if (r_i != 2'd2) begin
                            r_j     <= '0;
                            r_i     <= r_i + 2'd1;
                            r_state <= S_ISSUE;
                        end else begin
                            r_j <= '0;
                            r_i <= '0;
                            case (r_phase)
                                PH_QUAT:  r_state <= S_MAT;
                                PH_WORLD: r_state <= S_DECIDE;
                                default:  r_state <= S_OUT;
                            endcase
                        end
                    end
                end
                S_MAT: begin
                    r_m[0][0] <= w_one - MB'(2 * (MB'(r_pr[0][1]) + MB'(r_pr[0][2])));
                    r_m[0][1] <= MB'(2 * (MB'(r_pr[1][0]) - MB'(r_pr[2][2])));
                    r_m[0][2] <= MB'(2 * (MB'(r_pr[1][1]) + MB'(r_pr[2][1])));
                    r_m[1][0] <= MB'(2 * (MB'(r_pr[1][0]) + MB'(r_pr[2][2])));
                    r_m[1][1] <= w_one - MB'(2 * (MB'(r_pr[0][0]) + MB'(r_pr[0][2])));
                    r_m[1][2] <= MB'(2 * (MB'(r_pr[1][2]) - MB'(r_pr[2][0])));
                    r_m[2][0] <= MB'(2 * (MB'(r_pr[1][1]) - MB'(r_pr[2][1])));
                    r_m[2][1] <= MB'(2 * (MB'(r_pr[1][2]) + MB'(r_pr[2][0])));
                    r_m[2][2] <= w_one - MB'(2 * (MB'(r_pr[0][0]) + MB'(r_pr[0][1])));
                    r_phase   <= PH_WORLD;
                    r_state   <= S_ISSUE;
                end
                S_DECIDE: begin
                    if (r_calib) begin
                        for (int k = 0; k < 3; k++) begin
                            r_store[k] <= r_store[k] + SUMB'(r_wv[k]);
                            r_ro[k]    <= r_a[k];
                            r_rb[k]    <= '0;
                        end
                        r_rcorr <= 1'b0;
                        r_rdone <= 1'b0;
                        r_taken <= w_taken_n;
                        if (w_taken_n >= w_target) begin
                            r_dc    <= '0;
                            r_state <= S_DIVGO;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_meas_ok) begin
                                r_rb[k] <= r_store[k][WB-1:0];
                                r_d[k]  <= DB'(r_wv[k]) - DB'(r_store[k]);
                            end else begin
                                r_rb[k] <= r_preset[k];
                                r_d[k]  <= DB'(r_wv[k]) - DB'(r_preset[k]);
                            end
                        end
                        r_rcorr <= 1'b1;
                        r_rdone <= 1'b0;
                        r_phase <= PH_BACK;
                        r_state <= S_ISSUE;
                    end
                end
                S_DIVGO: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_store[r_dc] <= w_div_quo;
                        r_rb[r_dc]    <= w_div_quo[WB-1:0];
                        if (r_dc == 2'd2) begin
                            r_calib   <= 1'b0;
                            r_meas_ok <= 1'b1;
                            r_rdone   <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_dc    <= r_dc + 2'd1;
                            r_state <= S_DIVGO;
                        end
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            for (int k = 0; k < 3; k++) begin
                r_o[k]  <= r_ro[k];
                r_ob[k] <= r_rb[k];
            end
            r_ocorr <= r_rcorr;
            r_odone <= r_rdone;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_x      = r_o[0];
    assign o_out_y      = r_o[1];
    assign o_out_z      = r_o[2];
    assign o_bias_out_x = r_ob[0];
    assign o_bias_out_y = r_ob[1];
    assign o_bias_out_z = r_ob[2];
    assign o_corrected  = r_ocorr;
    assign o_calib_done = r_odone;

    `IABC_ASSERT_NEXT(a_start_arms, i_clk, i_rst_n, w_in_acc && i_kind, r_calib)
    `IABC_ASSERT_NOW(a_div_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIVW)
    `IABC_ASSERT_NOW(a_mul_in_wait, i_clk, i_rst_n, w_mul_valid, r_state == S_WAIT)
    `IABC_ASSERT_NOW(a_done_raw, i_clk, i_rst_n, o_valid && o_calib_done, !o_corrected)
endmodule
